/* rtl/core/srgb_to_cielab_macros.svh */
// Assertion macros used by the colour conversion RTL.
`ifndef SRGB_TO_CIELAB_MACROS_SVH
`define SRGB_TO_CIELAB_MACROS_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define S2C_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("colour conversion check failed");
// Check that cons holds in the cycle after ante.
`define S2C_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("colour conversion check failed");
`else
`define S2C_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define S2C_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/s2lab_pkg.sv */
// Constants, types and functions of the sRGB to CIELAB pipeline.
`default_nettype none

package s2lab_pkg;

	// Output format
	localparam int OUT_FRAC_BITS = 8;
	localparam int QB            = 20;
	localparam int RND_SH        = QB - OUT_FRAC_BITS;
	localparam int L_MAX         = ((100 << OUT_FRAC_BITS) > 32767) ? 32767 :
		(100 << OUT_FRAC_BITS);
	localparam int SAT_MIN       = -32768;
	localparam int SAT_MAX       = 32767;

	// Datapath widths
	localparam int LIN_W    = QB + 1;         // linear channel, Q.20 up to 1.0
	localparam int NUM_W    = 37;             // scaled matrix sums
	localparam int EST_W    = 24;             // top bits fed to the reciprocal
	localparam int EST_POST = 27;             // shift after the reciprocal product
	localparam int REM_W    = 18;             // remainder after the estimate
	localparam int T_W      = QB + 1;         // X/Xn, Y/Yn, Z/Zn in Q.20
	localparam int F_W      = QB + 1;         // f(t) in Q.20
	localparam int ACC_W    = 32;             // signed L, a, b before rounding
	localparam int CR_STEPS = 21;             // one root bit per stage
	localparam int RAD_W    = 3 * CR_STEPS;   // radicand t << 40, padded
	localparam int SQ_W     = 2 * T_W;
	localparam int RM_W     = SQ_W + 2;

	// Channel slots
	localparam int CH_X = 0;
	localparam int CH_Y = 1;
	localparam int CH_Z = 2;

	// RGB to XYZ matrix, each row already scaled so that one divider per row follows
	localparam logic [16:0] MAT_COEF [3][3] = '{
		'{17'd41240, 17'd35760, 17'd18050},
		'{17'd2126,  17'd7152,  17'd722},
		'{17'd1930,  17'd11920, 17'd95050}
	};

	// Row divisors (white point), rounding offsets and reciprocals
	localparam logic [16:0] DIV_D [3]    = '{17'd95047, 17'd10000, 17'd108883};
	localparam logic [16:0] DIV_HALF [3] = '{17'd47523, 17'd5000, 17'd54441};
	localparam int          DIV_SH [3]   = '{13, 10, 13};
	localparam logic [EST_W-1:0] DIV_M [3] = '{
		EST_W'((64'd1 << 40) / 64'd95047),
		EST_W'((64'd1 << 37) / 64'd10000),
		EST_W'((64'd1 << 40) / 64'd108883)
	};
	localparam logic [REM_W-1:0] DIV_REM_LIM [3] = '{
		REM_W'(2 * 95047), REM_W'(2 * 10000), REM_W'(2 * 108883)
	};

	// Linear segment of f(t): floor((7787t + 500) / 1000) + 16/116
	localparam logic [T_W-1:0] LAB_T_LIM = T_W'((64'd8856 << QB) / 64'd1000000);
	localparam int LAB_T_BITS = 14;
	localparam int NL_W       = 27;
	localparam int LQ_W       = 17;
	localparam int LREM_W     = 11;
	localparam int LAB_LIN_MUL = 7787;
	localparam int LAB_LIN_ADD = 500;
	localparam int LAB_DIV     = 1000;
	localparam int LAB_PRE_SH  = 3;
	localparam int LAB_POST    = 30;
	localparam logic [EST_W-1:0] LAB_M = EST_W'((64'd1 << 33) / 64'd1000);
	localparam int LAB_LIN_OFS = 144631;

	// Final scaling
	localparam int L_MUL = 116;
	localparam int A_MUL = 500;
	localparam int B_MUL = 200;
	localparam int L_OFS = 16 << QB;
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);

	typedef logic [255:0][LIN_W-1:0] lin_tab_t;

	// Cube root recurrence state
	typedef struct packed {
		logic [T_W-1:0]  t;
		logic [T_W-1:0]  y;
		logic [SQ_W-1:0] ysq;
		logic [RM_W-1:0] rem;
	} cr_t;

	// sRGB decoding of one 8-bit code to linear light, Q.20
	function automatic logic [LIN_W-1:0] lin_entry(input int unsigned c);
		longint unsigned u;
		longint unsigned u2;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned p;
		int k;
		if (c <= 10) begin
			return LIN_W'((64'(c) * 64'd10 * (64'd1 << QB) + 64'd16473) / 64'd32946);
		end
		u  = (((64'd1000 * 64'(c) + 64'd14025) << QB) + 64'd134512) / 64'd269025;
		u2 = (u * u + (64'd1 << (QB - 1))) >> QB;
		lo = 64'd0;
		hi = 64'd1 << QB;
		// largest r whose fifth power stays at or below u2
		while (lo < hi) begin
			mid = lo + ((hi - lo + 64'd1) >> 1);
			p = mid;
			for (k = 0; k < 4; k++) begin
				p = (p * mid) >> QB;
			end
			if (p <= u2) begin
				lo = mid;
			end else begin
				hi = mid - 64'd1;
			end
		end
		return LIN_W'((u2 * lo + (64'd1 << (QB - 1))) >> QB);
	endfunction

	function automatic lin_tab_t build_lin_tab();
		lin_tab_t tab;
		for (int c = 0; c < 256; c++) begin
			tab[c] = lin_entry(c);
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin_tab();

	// One bit of the restoring cube root: take in three radicand bits
	function automatic cr_t cr_step(input cr_t s, input logic [2:0] grp);
		cr_t o;
		logic [T_W-1:0] y2;
		logic [SQ_W-1:0] ysq4;
		logic [RM_W+2:0] racc;
		logic [RM_W+2:0] sum;
		logic [RM_W+2:0] b;
		y2   = {s.y[T_W-2:0], 1'b0};
		ysq4 = {s.ysq[SQ_W-3:0], 2'b00};
		racc = {s.rem, grp};
		sum  = (RM_W+3)'(ysq4) + (RM_W+3)'(y2);
		b    = {sum[RM_W+1:0], 1'b0} + sum + (RM_W+3)'(1);
		o.t  = s.t;
		if (racc >= b) begin
			o.y   = y2 + T_W'(1);
			o.ysq = ysq4 + SQ_W'({y2, 1'b0}) + SQ_W'(1);
			o.rem = RM_W'(racc - b);
		end else begin
			o.y   = y2;
			o.ysq = ysq4;
			o.rem = racc[RM_W-1:0];
		end
		return o;
	endfunction

	// Shift right by RND_SH, rounding half away from zero
	function automatic logic signed [ACC_W-1:0] round_away(
		input logic signed [ACC_W-1:0] v
	);
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] rnd;
		mag = (v < 0) ? ACC_W'(-v) : ACC_W'(v);
		rnd = (mag + RND_HALF) >> RND_SH;
		return (v < 0) ? -$signed(rnd) : $signed(rnd);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/srgb_to_cielab.sv */
// sRGB to CIELAB (D65) pixel converter, 34-stage pipeline.
//
//   channel  | direction | words carried                          | handshake
//   ---------+-----------+----------------------------------------+--------------------
//   input    | in        | red_in, green_in, blue_in              | in_valid / in_ready
//   output   | out       | lightness_out, green_red_out,          | out_valid / out_ready
//            |           | blue_yellow_out                        |
//
// One word enters per clock unless the output stalls; words leave in the order they enter.
// Most stages belong to the cube root, which resolves one root bit per stage
// over 21 stages, preceded by table lookup, matrix and white-point division.
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stage loads on out_ready or when it or any later stage is empty, so bubbles
// close up and a word is taken while a finished result waits in the output register.
`default_nettype none
`include "srgb_to_cielab_macros.svh"

module srgb_to_cielab (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  red_in,
	input  wire logic [7:0]  green_in,
	input  wire logic [7:0]  blue_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [14:0]      lightness_out,
	output logic signed [15:0] green_red_out,
	output logic signed [15:0] blue_yellow_out
);
	import s2lab_pkg::*;

	localparam int NS       = 34;
	localparam int CR_FIRST = 8;
	localparam int CR_LAST  = CR_FIRST + CR_STEPS - 1;

	logic [NS:1] vld_q;
	logic [NS:1] en;

	logic [2:0][LIN_W-1:0]            lin_s1;
	logic [2:0][2:0][NUM_W-1:0]       prod_s2;
	logic [2:0][NUM_W-1:0]            num_s3;
	logic [2:0][T_W-1:0]              est_s4;
	logic [2:0][NUM_W-1:0]            num_s4;
	logic [2:0][NUM_W-1:0]            dprod_s5;
	logic [2:0][T_W-1:0]              est_s5;
	logic [2:0][NUM_W-1:0]            num_s5;
	logic [2:0][REM_W-1:0]            rem_s6;
	logic [2:0][T_W-1:0]              est_s6;
	logic [2:0][T_W-1:0]              t_s7;
	cr_t  [2:0]                       cr_s [CR_STEPS];
	logic [2:0][NL_W-1:0]             nl_s29;
	logic [2:0][F_W-1:0]              root_s29;
	logic [2:0]                       hi_s29;
	logic [2:0][LQ_W-1:0]             lq_s30;
	logic [2:0][NL_W-1:0]             nl_s30;
	logic [2:0][F_W-1:0]              root_s30;
	logic [2:0]                       hi_s30;
	logic [2:0][NL_W-1:0]             lp_s31;
	logic [2:0][LQ_W-1:0]             lq_s31;
	logic [2:0][NL_W-1:0]             nl_s31;
	logic [2:0][F_W-1:0]              root_s31;
	logic [2:0]                       hi_s31;
	logic [2:0][LREM_W-1:0]           lrem;
	logic [2:0][F_W-1:0]              f_s32;
	logic signed [ACC_W-1:0]          fx, fy, fz;
	logic signed [ACC_W-1:0]          lv_s33, av_s33, bv_s33;
	logic signed [ACC_W-1:0]          lr, ar, br;
	logic [14:0]                      lightness_s34;
	logic signed [15:0]               gr_s34, by_s34;

	// Stage k loads on out_ready or when it or a later stage is free
	for (genvar k = 1; k <= NS; k++) begin : g_en
		assign en[k] = out_ready | ~(&vld_q[NS:k]);
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];

	// Advance the valid bits with their words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Decode the sRGB curve from the table
	always_ff @(posedge clk) begin
		if (en[1]) begin
			lin_s1[0] <= LIN_TAB[red_in];
			lin_s1[1] <= LIN_TAB[green_in];
			lin_s1[2] <= LIN_TAB[blue_in];
		end
	end

	// Form the matrix products
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int o = 0; o < 3; o++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s2[o][i] <= NUM_W'(MAT_COEF[o][i]) * NUM_W'(lin_s1[i]);
				end
			end
		end
	end

	// Sum each row and add half the divisor
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int o = 0; o < 3; o++) begin
				num_s3[o] <= prod_s2[o][0] + prod_s2[o][1] + prod_s2[o][2] +
					NUM_W'(DIV_HALF[o]);
			end
		end
	end

	// Estimate the quotient by reciprocal, never above the true value
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int o = 0; o < 3; o++) begin
				est_s4[o] <= T_W'(((2*EST_W)'(EST_W'(num_s3[o] >> DIV_SH[o])) *
					(2*EST_W)'(DIV_M[o])) >> EST_POST);
				num_s4[o] <= num_s3[o];
			end
		end
	end

	// Multiply the estimate back by the divisor
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int o = 0; o < 3; o++) begin
				dprod_s5[o] <= NUM_W'(est_s4[o]) * NUM_W'(DIV_D[o]);
				est_s5[o]   <= est_s4[o];
				num_s5[o]   <= num_s4[o];
			end
		end
	end

	// Take the remainder
	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int o = 0; o < 3; o++) begin
				rem_s6[o] <= REM_W'(num_s5[o] - dprod_s5[o]);
				est_s6[o] <= est_s5[o];
			end
		end
	end

	// Correct the quotient by one where the remainder reaches the divisor
	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int o = 0; o < 3; o++) begin
				t_s7[o] <= est_s6[o] + T_W'(rem_s6[o] >= REM_W'(DIV_D[o]));
			end
		end
	end

	// Cube root of t in Q.20, one root bit per stage
	for (genvar k = 0; k < CR_STEPS; k++) begin : g_cr
		cr_t  [2:0]       cr_in;
		logic [2:0][RAD_W-1:0] rad;

		if (k == 0) begin : g_head
			for (genvar o = 0; o < 3; o++) begin : g_ch
				assign cr_in[o].t   = t_s7[o];
				assign cr_in[o].y   = '0;
				assign cr_in[o].ysq = '0;
				assign cr_in[o].rem = '0;
			end
		end else begin : g_body
			assign cr_in = cr_s[k-1];
		end

		for (genvar o = 0; o < 3; o++) begin : g_rad
			assign rad[o] = {cr_in[o].t, (RAD_W - T_W)'(0)} >> (RAD_W - T_W - 2 * QB);
		end

		always_ff @(posedge clk) begin
			if (en[CR_FIRST + k]) begin
				for (int o = 0; o < 3; o++) begin
					cr_s[k][o] <= cr_step(cr_in[o], rad[o][RAD_W-1-3*k -: 3]);
				end
			end
		end
	end

	// Pick the segment and start the linear branch
	always_ff @(posedge clk) begin
		if (en[CR_LAST + 1]) begin
			for (int o = 0; o < 3; o++) begin
				hi_s29[o]   <= cr_s[CR_STEPS-1][o].t > LAB_T_LIM;
				root_s29[o] <= cr_s[CR_STEPS-1][o].y;
				nl_s29[o]   <= NL_W'(LAB_LIN_MUL) *
					NL_W'(cr_s[CR_STEPS-1][o].t[LAB_T_BITS-1:0]) + NL_W'(LAB_LIN_ADD);
			end
		end
	end

	// Estimate the linear branch quotient by 1000
	always_ff @(posedge clk) begin
		if (en[CR_LAST + 2]) begin
			for (int o = 0; o < 3; o++) begin
				lq_s30[o]   <= LQ_W'(((2*EST_W)'(EST_W'(nl_s29[o] >> LAB_PRE_SH)) *
					(2*EST_W)'(LAB_M)) >> LAB_POST);
				nl_s30[o]   <= nl_s29[o];
				root_s30[o] <= root_s29[o];
				hi_s30[o]   <= hi_s29[o];
			end
		end
	end

	// Multiply back by 1000
	always_ff @(posedge clk) begin
		if (en[CR_LAST + 3]) begin
			for (int o = 0; o < 3; o++) begin
				lp_s31[o]   <= NL_W'(lq_s30[o]) * NL_W'(LAB_DIV);
				lq_s31[o]   <= lq_s30[o];
				nl_s31[o]   <= nl_s30[o];
				root_s31[o] <= root_s30[o];
				hi_s31[o]   <= hi_s30[o];
			end
		end
	end

	always_comb begin
		for (int o = 0; o < 3; o++) begin
			lrem[o] = LREM_W'(nl_s31[o] - lp_s31[o]);
		end
	end

	// Settle f(t) for each channel
	always_ff @(posedge clk) begin
		if (en[CR_LAST + 4]) begin
			for (int o = 0; o < 3; o++) begin
				f_s32[o] <= hi_s31[o] ? root_s31[o] :
					F_W'(lq_s31[o]) + F_W'(lrem[o] >= LREM_W'(LAB_DIV)) +
					F_W'(LAB_LIN_OFS);
			end
		end
	end

	assign fx = $signed(ACC_W'(f_s32[CH_X]));
	assign fy = $signed(ACC_W'(f_s32[CH_Y]));
	assign fz = $signed(ACC_W'(f_s32[CH_Z]));

	// Scale into L, a and b
	always_ff @(posedge clk) begin
		if (en[CR_LAST + 5]) begin
			lv_s33 <= fy * L_MUL - L_OFS;
			av_s33 <= (fx - fy) * A_MUL;
			bv_s33 <= (fy - fz) * B_MUL;
		end
	end

	assign lr = round_away(lv_s33);
	assign ar = round_away(av_s33);
	assign br = round_away(bv_s33);

	// Round, clamp and hold the result for the consumer
	always_ff @(posedge clk) begin
		if (en[NS]) begin
			lightness_s34 <= (lr < 0) ? 15'd0 : ((lr > L_MAX) ? 15'(L_MAX) : lr[14:0]);
			gr_s34 <= (ar < SAT_MIN) ? 16'(SAT_MIN) :
				((ar > SAT_MAX) ? 16'(SAT_MAX) : ar[15:0]);
			by_s34 <= (br < SAT_MIN) ? 16'(SAT_MIN) :
				((br > SAT_MAX) ? 16'(SAT_MAX) : br[15:0]);
		end
	end

	assign lightness_out   = lightness_s34;
	assign green_red_out   = gr_s34;
	assign blue_yellow_out = by_s34;

	// Words in flight change only by what enters and leaves
	`S2C_ASSERT_NXT(a_occupancy, clk, arst_n, 1'b1, $countones(vld_q) == $past($countones(vld_q)) + ($past(in_valid && in_ready) ? 1 : 0) - ($past(out_valid && out_ready) ? 1 : 0))
	// The reciprocal estimate is at most one short
	`S2C_ASSERT_IMP(a_div_rem, clk, arst_n, vld_q[6], (rem_s6[CH_X] < DIV_REM_LIM[CH_X]) && (rem_s6[CH_Y] < DIV_REM_LIM[CH_Y]) && (rem_s6[CH_Z] < DIV_REM_LIM[CH_Z]))
	`S2C_ASSERT_IMP(a_lin_rem, clk, arst_n, vld_q[CR_LAST + 3], (lrem[CH_X] < LREM_W'(2 * LAB_DIV)) && (lrem[CH_Y] < LREM_W'(2 * LAB_DIV)) && (lrem[CH_Z] < LREM_W'(2 * LAB_DIV)))
	// Lightness stays within 0 to 100
	`S2C_ASSERT_IMP(a_l_range, clk, arst_n, out_valid, lightness_out <= 15'(L_MAX))

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the sRGB to CIELAB pixel converter.
`timescale 1ns / 1ps

module tb;
	import s2lab_pkg::OUT_FRAC_BITS;

	localparam int HALF_PERIOD  = 4;
	localparam int DRAIN_CYCLES = 64;
	localparam int PRINT_LIMIT  = 40;
	localparam int RANDOM_WORDS = 1080;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		bit         drain_first;
	} pixel_t;

	typedef struct {
		logic [14:0]        lightness;
		logic signed [15:0] green_red;
		logic signed [15:0] blue_yellow;
	} lab_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] red_in = 8'd0;
	logic [7:0] green_in = 8'd0;
	logic [7:0] blue_in = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [14:0] lightness_out;
	logic signed [15:0] green_red_out;
	logic signed [15:0] blue_yellow_out;

	pixel_t pending_pixels[$];
	lab_t   expected_lab[$];
	int     pixels_total = 1;
	int     pixels_sent = 0;
	int     mismatches = 0;

	srgb_to_cielab dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.red_in          (red_in),
		.green_in        (green_in),
		.blue_in         (blue_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.lightness_out   (lightness_out),
		.green_red_out   (green_red_out),
		.blue_yellow_out (blue_yellow_out)
	);

	always #HALF_PERIOD clk = ~clk;

	// Decode one sRGB code to linear light, Q.20
	function automatic longint unsigned srgb_decode(input logic [7:0] code);
		longint unsigned c;
		longint unsigned u;
		longint unsigned u2;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned p;
		c = longint'(code);
		if (c <= 10) begin
			return (c * 10 * (64'd1 << 20) + 16473) / 32946;
		end
		u  = (((1000 * c + 14025) << 20) + 134512) / 269025;
		u2 = (u * u + (64'd1 << 19)) >> 20;
		// search the largest r whose truncated fifth power fits under u2
		lo = 0;
		hi = 64'd1 << 20;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			p = mid;
			for (int k = 0; k < 4; k++) begin
				p = (p * mid) >> 20;
			end
			if (p <= u2) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return (u2 * lo + (64'd1 << 19)) >> 20;
	endfunction

	// CIELAB companding curve: exact floor cube root, linear toe below the knee
	function automatic longint unsigned lab_curve(input longint unsigned t);
		longint unsigned target;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		if (t * 1000000 > (64'd8856 << 20)) begin
			if (t > (64'd1 << 21)) begin
				t = 64'd1 << 21;
			end
			target = t << 40;
			lo = 0;
			hi = (64'd1 << 21) - 1;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				if (mid * mid * mid <= target) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
			return lo;
		end
		return (7787 * t + 500) / 1000 + 144631;
	endfunction

	// Drop the extra fraction bits, rounding half away from zero
	function automatic longint round_to_out(input longint v);
		longint unsigned half;
		int sh;
		sh = 20 - OUT_FRAC_BITS;
		half = 64'd1 << (sh - 1);
		if (v >= 0) begin
			return longint'((longint'(v) + half) >> sh);
		end
		return -longint'((longint'(-v) + half) >> sh);
	endfunction

	function automatic lab_t convert_pixel(input pixel_t px);
		lab_t res;
		longint unsigned lr;
		longint unsigned lg;
		longint unsigned lb;
		longint fx;
		longint fy;
		longint fz;
		longint lv;
		longint av;
		longint bv;
		longint lmax;
		lr = srgb_decode(px.red);
		lg = srgb_decode(px.green);
		lb = srgb_decode(px.blue);
		// matrix row, then divide by the white point, half up
		fx = longint'(lab_curve((10 * (4124 * lr + 3576 * lg + 1805 * lb) + 47523) / 95047));
		fy = longint'(lab_curve((2126 * lr + 7152 * lg + 722 * lb + 5000) / 10000));
		fz = longint'(lab_curve((10 * (193 * lr + 1192 * lg + 9505 * lb) + 54441) / 108883));
		lv = round_to_out(116 * fy - (longint'(16) << 20));
		av = round_to_out(500 * (fx - fy));
		bv = round_to_out(200 * (fy - fz));
		lmax = longint'(100) << OUT_FRAC_BITS;
		if (lmax > 32767) begin
			lmax = 32767;
		end
		// saturate to the field ranges
		if (lv < 0) lv = 0;
		if (lv > lmax) lv = lmax;
		if (av < -32768) av = -32768;
		if (av > 32767) av = 32767;
		if (bv < -32768) bv = -32768;
		if (bv > 32767) bv = 32767;
		res.lightness   = lv[14:0];
		res.green_red   = av[15:0];
		res.blue_yellow = bv[15:0];
		return res;
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("%0t mismatch: %s", $realtime, msg);
		end
	endtask

	// Idle rates per phase: sender light then heavy, receiver the reverse, then none
	function automatic int sender_idle_pct(input int sent);
		case (sent * 3 / pixels_total)
			0: begin
				return 10;
			end
			1: begin
				return 80;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	function automatic int receiver_idle_pct(input int sent);
		case (sent * 3 / pixels_total)
			0: begin
				return 80;
			end
			1: begin
				return 10;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	function automatic pixel_t make_pixel(input int r, input int g, input int b);
		pixel_t px;
		px.red = r[7:0];
		px.green = g[7:0];
		px.blue = b[7:0];
		px.drain_first = 1'b0;
		return px;
	endfunction

	// Driver: present the next word once the slot is free
	always @(posedge clk or negedge arst_n) begin
		pixel_t px;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				px.red = red_in;
				px.green = green_in;
				px.blue = blue_in;
				px.drain_first = 1'b0;
				expected_lab.push_back(convert_pixel(px));
				pixels_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_pixels.size() > 0 &&
						$urandom_range(99) >= sender_idle_pct(pixels_sent) &&
						!(pending_pixels[0].drain_first && expected_lab.size() != 0)) begin
					px = pending_pixels.pop_front();
					red_in   <= px.red;
					green_in <= px.green;
					blue_in  <= px.blue;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each finished word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		lab_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_lab.size() == 0) begin
					report($sformatf("unexpected word L=%0d a=%0d b=%0d",
						lightness_out, green_red_out, blue_yellow_out));
				end else begin
					want = expected_lab.pop_front();
					if (lightness_out !== want.lightness) begin
						report($sformatf("lightness got %0d want %0d",
							lightness_out, want.lightness));
					end
					if (green_red_out !== want.green_red) begin
						report($sformatf("green_red got %0d want %0d",
							green_red_out, want.green_red));
					end
					if (blue_yellow_out !== want.blue_yellow) begin
						report($sformatf("blue_yellow got %0d want %0d",
							blue_yellow_out, want.blue_yellow));
					end
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_idle_pct(pixels_sent));
		end
	end

	// Stimulus and end of run
	initial begin
		pixel_t px;
		int pick;
		// corners, primaries and secondaries
		pending_pixels.push_back(make_pixel(0, 0, 0));
		pending_pixels.push_back(make_pixel(255, 255, 255));
		pending_pixels.push_back(make_pixel(255, 0, 0));
		pending_pixels.push_back(make_pixel(0, 255, 0));
		pending_pixels.push_back(make_pixel(0, 0, 255));
		pending_pixels.push_back(make_pixel(255, 255, 0));
		pending_pixels.push_back(make_pixel(0, 255, 255));
		pending_pixels.push_back(make_pixel(255, 0, 255));
		// either side of the linear segment of the sRGB curve
		pending_pixels.push_back(make_pixel(10, 10, 10));
		pending_pixels.push_back(make_pixel(11, 11, 11));
		pending_pixels.push_back(make_pixel(10, 11, 10));
		// tiny values on the linear toe of the Lab curve
		pending_pixels.push_back(make_pixel(1, 0, 0));
		pending_pixels.push_back(make_pixel(0, 1, 0));
		pending_pixels.push_back(make_pixel(0, 0, 1));
		// greys around the knee of the Lab curve, and mid grey
		pending_pixels.push_back(make_pixel(23, 23, 23));
		pending_pixels.push_back(make_pixel(24, 24, 24));
		pending_pixels.push_back(make_pixel(25, 25, 25));
		pending_pixels.push_back(make_pixel(128, 128, 128));
		// strongest chroma on each axis
		pending_pixels.push_back(make_pixel(255, 0, 255));
		pending_pixels.push_back(make_pixel(0, 0, 255));
		pending_pixels.push_back(make_pixel(255, 255, 1));
		pending_pixels.push_back(make_pixel(170, 85, 0));
		// hold the next word until the pipe has drained
		px = make_pixel(255, 128, 1);
		px.drain_first = 1'b1;
		pending_pixels.push_back(px);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				px = make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
			end else if (pick < 85) begin
				px = make_pixel($urandom_range(30), $urandom_range(30), $urandom_range(30));
			end else begin
				// extremes mixed with random channels
				px = make_pixel($urandom_range(1) * 255, $urandom_range(1) * 255,
					$urandom_range(255));
			end
			pending_pixels.push_back(px);
		end
		pixels_total = pending_pixels.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_pixels.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (expected_lab.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
